[rtl/core/dh_forward_kinematics_6dof_top_assert.svh]
// Assertion macros for the arm pose block.
`ifndef DH_FORWARD_KINEMATICS_6DOF_TOP_ASSERT_SVH
`define DH_FORWARD_KINEMATICS_6DOF_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DHFK_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhfk: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DHFK_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dhfk: next-cycle check failed");

`endif

[rtl/core/dhfk_pkg.sv]
// Shared types, constants and tables of the arm pose block.
`default_nettype none
package dhfk_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int JOINT_COUNT    = 6;
  localparam int CORDIC_STEPS   = 24;
  localparam int STEP_W         = 5;
  localparam int PHASE_W        = 32;
  localparam int TRIG_W         = 32;
  localparam int TRIG_FRAC      = 30;
  localparam int POS_FRAC       = 8;
  localparam int LEN_W          = 16;
  localparam int LP_W           = 26;
  localparam int POS_W          = 32;
  localparam int OUT_ROT_W      = 16;
  localparam int OUT_POS_W      = 20;
  localparam int CFG_INDEX_W    = 3;
  localparam int QUEUE_DEPTH    = 2;
  localparam int JOINT_W        = 3;
  localparam int ROW_W          = 2;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 32'sd652032874;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE        = 32'sd1073741824;
  localparam int ROT_LIMIT = 16384;
  localparam int POS_MAX   = 524287;
  localparam int POS_MIN   = -524288;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_HEIGHT      = 3'd0,
    REG_UPPER_ARM_LENGTH = 3'd1,
    REG_FOREARM_LENGTH   = 3'd2,
    REG_WRIST1_OFFSET    = 3'd3,
    REG_WRIST2_OFFSET    = 3'd4,
    REG_TOOL_OFFSET      = 3'd5
  } reg_index_t;

  // Joint numbers along the chain.
  localparam logic [JOINT_W-1:0] JNT_BASE   = 3'd0;
  localparam logic [JOINT_W-1:0] JNT_SHLDR  = 3'd1;
  localparam logic [JOINT_W-1:0] JNT_ELBOW  = 3'd2;
  localparam logic [JOINT_W-1:0] JNT_WRIST1 = 3'd3;
  localparam logic [JOINT_W-1:0] JNT_WRIST2 = 3'd4;
  localparam logic [JOINT_W-1:0] JNT_WRIST3 = 3'd5;

  typedef logic [LEN_W-1:0] len_t;
  typedef len_t [JOINT_COUNT-1:0] cfg_t;

  typedef logic signed [TRIG_W-1:0] trig_val_t;
  typedef logic signed [LP_W-1:0] lp_t;

  typedef struct packed {
    trig_val_t s;
    trig_val_t c;
  } trig_t;

  // One queue entry: sin/cos of every joint, plus the rotated arm lengths
  // of shoulder (element 0) and elbow (element 1).
  typedef struct packed {
    trig_t [JOINT_COUNT-1:0] trig;
    lp_t [1:0] lp_c;
    lp_t [1:0] lp_s;
  } joint_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {F_IDLE, F_ROT, F_LEN, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_RUN, B_DRAIN, B_DONE} back_state_t;

  // atan(2^-i), one turn = 2^32.
  function automatic logic [PHASE_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [PHASE_W-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/dhfk_channels.sv]
// Request channel interfaces: joint angles in, pose out, register writes.
`default_nettype none
interface dhfk_in_if import dhfk_pkg::*; #(parameter int ANGLE_BITS = ANGLE_BITS_DEF) ();
  logic valid;
  logic ready;
  logic signed [ANGLE_BITS-1:0] angle_base;
  logic signed [ANGLE_BITS-1:0] angle_shoulder;
  logic signed [ANGLE_BITS-1:0] angle_elbow;
  logic signed [ANGLE_BITS-1:0] angle_wrist_one;
  logic signed [ANGLE_BITS-1:0] angle_wrist_two;
  logic signed [ANGLE_BITS-1:0] angle_wrist_three;
  modport source (output valid, angle_base, angle_shoulder, angle_elbow, angle_wrist_one,
                  angle_wrist_two, angle_wrist_three, input ready);
  modport sink (input valid, angle_base, angle_shoulder, angle_elbow, angle_wrist_one,
                angle_wrist_two, angle_wrist_three, output ready);
endinterface

interface dhfk_out_if import dhfk_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [OUT_ROT_W-1:0] rot_r0c0;
  logic signed [OUT_ROT_W-1:0] rot_r0c1;
  logic signed [OUT_ROT_W-1:0] rot_r0c2;
  logic signed [OUT_ROT_W-1:0] rot_r1c0;
  logic signed [OUT_ROT_W-1:0] rot_r1c1;
  logic signed [OUT_ROT_W-1:0] rot_r1c2;
  logic signed [OUT_ROT_W-1:0] rot_r2c0;
  logic signed [OUT_ROT_W-1:0] rot_r2c1;
  logic signed [OUT_ROT_W-1:0] rot_r2c2;
  logic signed [OUT_POS_W-1:0] pos_x;
  logic signed [OUT_POS_W-1:0] pos_y;
  logic signed [OUT_POS_W-1:0] pos_z;
  modport source (output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
                  rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
                rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z, output ready);
endinterface

interface dhfk_cfg_if import dhfk_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [LEN_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/dhfk_queue.sv]
// Two-entry queue of joint sin/cos sets between front and back.
`default_nettype none
module dhfk_queue import dhfk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  joint_set_t wdata,
  input  logic       pop,
  output joint_set_t rdata,
  output q_stat_t    stat
);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  joint_set_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
endmodule
`default_nettype wire

[rtl/core/dhfk_front.sv]
// Front: takes joint angle requests, runs six CORDIC lanes, queues sin/cos.
`default_nettype none
module dhfk_front import dhfk_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dhfk_in_if.sink    joints,
  input  cfg_t       lengths,
  input  q_stat_t    q_stat,
  output logic       push,
  output joint_set_t push_data
);
  localparam int PAD_W  = PHASE_W - ANGLE_BITS;
  localparam int PROD_W = LEN_W + 1 + TRIG_W;

  front_state_t state, state_next;
  logic take;

  logic buf_valid;
  logic signed [ANGLE_BITS-1:0] buf_ang [JOINT_COUNT];

  logic [STEP_W-1:0] step;
  logic signed [TRIG_W-1:0] x [JOINT_COUNT];
  logic signed [TRIG_W-1:0] y [JOINT_COUNT];
  logic signed [PHASE_W:0]  z [JOINT_COUNT];
  logic flip [JOINT_COUNT];

  trig_val_t s_fin [JOINT_COUNT];
  trig_val_t c_fin [JOINT_COUNT];
  logic signed [PROD_W-1:0] prod_c [2];
  logic signed [PROD_W-1:0] prod_s [2];

  // input holding stage
  assign joints.ready = !buf_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (joints.valid && joints.ready) begin
      buf_valid <= 1'b1;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (joints.valid && joints.ready) begin
      buf_ang[0] <= joints.angle_base;
      buf_ang[1] <= joints.angle_shoulder;
      buf_ang[2] <= joints.angle_elbow;
      buf_ang[3] <= joints.angle_wrist_one;
      buf_ang[4] <= joints.angle_wrist_two;
      buf_ang[5] <= joints.angle_wrist_three;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (buf_valid) state_next = F_ROT;
      F_ROT:   if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = F_LEN;
      F_LEN:   state_next = F_PUSH;
      F_PUSH:  if (!q_stat.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    take = 1'b0;
    push = 1'b0;
    case (state)
      F_IDLE:  take = buf_valid;
      F_PUSH:  push = !q_stat.full;
      default: ;
    endcase
  end

  // CORDIC lanes, one micro-rotation per cycle
  always_ff @(posedge clk) begin
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] ph_q;
    logic fl;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [PHASE_W:0] at;
    if (take) begin
      step <= '0;
      for (int j = 0; j < JOINT_COUNT; j++) begin
        ph   = {buf_ang[j], {PAD_W{1'b0}}};
        ph_q = ph + 32'h4000_0000;
        fl   = ph_q[PHASE_W-1];
        if (fl) begin
          ph = {~ph[PHASE_W-1], ph[PHASE_W-2:0]};
        end
        flip[j] <= fl;
        x[j]    <= CORDIC_GAIN_INV;
        y[j]    <= '0;
        z[j]    <= $signed({ph[PHASE_W-1], ph});
      end
    end else if (state == F_ROT) begin
      step <= step + 1'b1;
      for (int j = 0; j < JOINT_COUNT; j++) begin
        dx = y[j] >>> step;
        dy = x[j] >>> step;
        at = $signed({1'b0, atan_lut(step)});
        if (!z[j][PHASE_W]) begin
          x[j] <= x[j] - dx;
          y[j] <= y[j] + dy;
          z[j] <= z[j] - at;
        end else begin
          x[j] <= x[j] + dx;
          y[j] <= y[j] - dy;
          z[j] <= z[j] + at;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < JOINT_COUNT; j++) begin
      s_fin[j] = flip[j] ? -y[j] : y[j];
      c_fin[j] = flip[j] ? -x[j] : x[j];
    end
  end

  // arm lengths rotated into the link frame (shoulder and elbow only)
  always_ff @(posedge clk) begin
    if (state == F_LEN) begin
      prod_c[0] <= $signed({1'b0, lengths[REG_UPPER_ARM_LENGTH]}) * c_fin[JNT_SHLDR];
      prod_s[0] <= $signed({1'b0, lengths[REG_UPPER_ARM_LENGTH]}) * s_fin[JNT_SHLDR];
      prod_c[1] <= $signed({1'b0, lengths[REG_FOREARM_LENGTH]}) * c_fin[JNT_ELBOW];
      prod_s[1] <= $signed({1'b0, lengths[REG_FOREARM_LENGTH]}) * s_fin[JNT_ELBOW];
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] t;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      push_data.trig[j].s = s_fin[j];
      push_data.trig[j].c = c_fin[j];
    end
    for (int k = 0; k < 2; k++) begin
      t = prod_c[k] + (PROD_W'(1) <<< (TRIG_FRAC - POS_FRAC - 1));
      push_data.lp_c[k] = t[TRIG_FRAC-POS_FRAC +: LP_W];
      t = prod_s[k] + (PROD_W'(1) <<< (TRIG_FRAC - POS_FRAC - 1));
      push_data.lp_s[k] = t[TRIG_FRAC-POS_FRAC +: LP_W];
    end
  end
endmodule
`default_nettype wire

[rtl/core/dhfk_back.sv]
// Back: chains the six link transforms row by row and drives the pose.
`default_nettype none
module dhfk_back import dhfk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       lengths,
  input  joint_set_t head,
  input  q_stat_t    q_stat,
  output logic       pop,
  dhfk_out_if.source pose
);
  localparam int PW   = 2 * TRIG_W;
  localparam int LP2W = LEN_W + POS_FRAC + 1;

  back_state_t state, state_next;
  logic start;
  logic issue;

  logic [ROW_W-1:0]   row;
  logic [JOINT_W-1:0] jnt;

  logic signed [TRIG_W-1:0] rot_row [3][3];
  logic signed [POS_W-1:0]  pos_row [3];

  // multiply stage
  logic a_valid;
  logic [ROW_W-1:0] a_row;
  logic [JOINT_W-1:0] a_jnt;
  logic signed [PW-1:0] p0c, p1s, p1c, p0s, pl0, pl1, pl2;
  logic signed [TRIG_W-1:0] a_rot2;
  logic signed [POS_W-1:0] a_pos;

  function automatic logic signed [TRIG_W-1:0] rnd30(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v + (PW'(1) <<< (TRIG_FRAC - 1));
    return t[TRIG_FRAC +: TRIG_W];
  endfunction

  function automatic logic signed [OUT_ROT_W-1:0] rot_out(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W:0] t;
    logic signed [TRIG_W-TRIG_FRAC+14:0] q;
    t = {v[TRIG_W-1], v} + (33'sd1 <<< (TRIG_FRAC - 15));
    q = t[TRIG_W:TRIG_FRAC-14];
    if (q > ROT_LIMIT) return OUT_ROT_W'(ROT_LIMIT);
    if (q < -ROT_LIMIT) return OUT_ROT_W'(-ROT_LIMIT);
    return q[OUT_ROT_W-1:0];
  endfunction

  function automatic logic signed [OUT_POS_W-1:0] pos_out(input logic signed [POS_W-1:0] v);
    logic signed [POS_W:0] t;
    logic signed [POS_W-POS_FRAC:0] q;
    t = {v[POS_W-1], v} + (33'sd1 <<< (POS_FRAC - 1));
    q = t[POS_W:POS_FRAC];
    if (q > POS_MAX) return OUT_POS_W'(POS_MAX);
    if (q < POS_MIN) return OUT_POS_W'(POS_MIN);
    return q[OUT_POS_W-1:0];
  endfunction

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_stat.empty) state_next = B_RUN;
      B_RUN:   if (jnt == JNT_WRIST3 && row == ROW_W'(2)) state_next = B_DRAIN;
      B_DRAIN: state_next = B_DONE;
      B_DONE:  if (!pose.valid || pose.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    start = 1'b0;
    issue = 1'b0;
    pop   = 1'b0;
    case (state)
      B_IDLE:  start = !q_stat.empty;
      B_RUN:   issue = 1'b1;
      B_DONE:  pop = !pose.valid || pose.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      jnt     <= '0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= issue;
      if (start) begin
        row <= '0;
        jnt <= '0;
      end else if (issue) begin
        if (row == ROW_W'(2)) begin
          row <= '0;
          jnt <= jnt + 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

  // multiply stage: one row of the running product against joint jnt
  always_ff @(posedge clk) begin
    trig_t tr;
    lp_t lp0;
    lp_t lp1;
    logic [LEN_W-1:0] d;
    logic signed [LP2W-1:0] lp2;
    if (issue) begin
      tr  = head.trig[jnt];
      lp0 = '0;
      lp1 = '0;
      d   = '0;
      case (jnt)
        JNT_SHLDR: begin
          lp0 = head.lp_c[0];
          lp1 = head.lp_s[0];
        end
        JNT_ELBOW: begin
          lp0 = head.lp_c[1];
          lp1 = head.lp_s[1];
        end
        JNT_BASE:   d = lengths[REG_BASE_HEIGHT];
        JNT_WRIST1: d = lengths[REG_WRIST1_OFFSET];
        JNT_WRIST2: d = lengths[REG_WRIST2_OFFSET];
        JNT_WRIST3: d = lengths[REG_TOOL_OFFSET];
        default: ;
      endcase
      lp2 = $signed({1'b0, d, {POS_FRAC{1'b0}}});
      p0c <= PW'(rot_row[row][0]) * PW'(tr.c);
      p1s <= PW'(rot_row[row][1]) * PW'(tr.s);
      p1c <= PW'(rot_row[row][1]) * PW'(tr.c);
      p0s <= PW'(rot_row[row][0]) * PW'(tr.s);
      pl0 <= PW'(rot_row[row][0]) * PW'(lp0);
      pl1 <= PW'(rot_row[row][1]) * PW'(lp1);
      pl2 <= PW'(rot_row[row][2]) * PW'(lp2);
      a_rot2 <= rot_row[row][2];
      a_pos  <= pos_row[row];
      a_row  <= row;
      a_jnt  <= jnt;
    end
  end

  // sum stage: round and write the row back
  always_ff @(posedge clk) begin
    logic signed [PW-1:0] u;
    logic signed [PW-1:0] w;
    logic signed [PW-1:0] pacc;
    if (start) begin
      for (int r = 0; r < 3; r++) begin
        pos_row[r] <= '0;
        for (int c = 0; c < 3; c++) begin
          rot_row[r][c] <= (r == c) ? TRIG_ONE : '0;
        end
      end
    end else if (a_valid) begin
      u    = p0c + p1s;
      w    = p1c - p0s;
      pacc = pl0 + pl1 + pl2;
      rot_row[a_row][0] <= rnd30(u);
      pos_row[a_row]    <= a_pos + POS_W'(rnd30(pacc));
      case (a_jnt)
        JNT_BASE, JNT_WRIST1: begin
          // twist +90 degrees
          rot_row[a_row][1] <= a_rot2;
          rot_row[a_row][2] <= rnd30(-w);
        end
        JNT_WRIST2: begin
          // twist -90 degrees
          rot_row[a_row][1] <= -a_rot2;
          rot_row[a_row][2] <= rnd30(w);
        end
        default: begin
          rot_row[a_row][1] <= rnd30(w);
          rot_row[a_row][2] <= a_rot2;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pose.valid <= 1'b0;
    end else if (pop) begin
      pose.valid <= 1'b1;
    end else if (pose.ready) begin
      pose.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pose.rot_r0c0 <= rot_out(rot_row[0][0]);
      pose.rot_r0c1 <= rot_out(rot_row[0][1]);
      pose.rot_r0c2 <= rot_out(rot_row[0][2]);
      pose.rot_r1c0 <= rot_out(rot_row[1][0]);
      pose.rot_r1c1 <= rot_out(rot_row[1][1]);
      pose.rot_r1c2 <= rot_out(rot_row[1][2]);
      pose.rot_r2c0 <= rot_out(rot_row[2][0]);
      pose.rot_r2c1 <= rot_out(rot_row[2][1]);
      pose.rot_r2c2 <= rot_out(rot_row[2][2]);
      pose.pos_x    <= pos_out(pos_row[0]);
      pose.pos_y    <= pos_out(pos_row[1]);
      pose.pos_z    <= pos_out(pos_row[2]);
    end
  end
endmodule
`default_nettype wire

[rtl/core/dh_forward_kinematics_6dof_top.sv]
// Top level of the six-joint arm pose block.
`default_nettype none
// Six-joint arm forward kinematics. Each request on "joints" carries six
// signed binary angles (full scale +/- pi); the block answers with one
// request on "pose": the 3x3 tool rotation in Q2.14 (saturated to +/-1.0)
// and the tool position in 2^-15 m, saturated to 20 bits. Link twists are
// fixed at 90, 0, 0, 90, -90 and 0 degrees; the six nonzero lengths and
// offsets are registers 0..5 on "cfg" (writes to other indexes are dropped),
// and are to be written only while no request is in flight.
// Unless the output stalls, throughput is set by the front end, where six
// CORDIC lanes each do one of 24 micro-rotations per cycle, then form the
// arm-length products, queue the result and take the next angles. Per pose,
// the back end has a start step, 18 row steps (three rows times six joints
// through a two-stage multiply and round pipe), a drain step and a load of
// the output register. A two-entry queue lets the front run ahead while a
// finished pose waits on "pose.ready", and the input holding register
// takes the next angles while the CORDIC is busy.
module dh_forward_kinematics_6dof_top import dhfk_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dhfk_in_if.sink    joints,
  dhfk_out_if.source pose,
  dhfk_cfg_if.sink   cfg
);
`include "dh_forward_kinematics_6dof_top_assert.svh"

  cfg_t       cfg_regs;
  logic       q_push;
  logic       q_pop;
  joint_set_t q_wdata;
  joint_set_t q_rdata;
  q_stat_t    q_stat;

  // register writes are taken every cycle
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs[REG_BASE_HEIGHT]      <= 16'd3791;
      cfg_regs[REG_UPPER_ARM_LENGTH] <= 16'd18753;
      cfg_regs[REG_FOREARM_LENGTH]   <= 16'd18478;
      cfg_regs[REG_WRIST1_OFFSET]    <= 16'd5633;
      cfg_regs[REG_WRIST2_OFFSET]    <= 16'd4171;
      cfg_regs[REG_TOOL_OFFSET]      <= 16'd7238;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_BASE_HEIGHT:      cfg_regs[REG_BASE_HEIGHT]      <= cfg.data;
        REG_UPPER_ARM_LENGTH: cfg_regs[REG_UPPER_ARM_LENGTH] <= cfg.data;
        REG_FOREARM_LENGTH:   cfg_regs[REG_FOREARM_LENGTH]   <= cfg.data;
        REG_WRIST1_OFFSET:    cfg_regs[REG_WRIST1_OFFSET]    <= cfg.data;
        REG_WRIST2_OFFSET:    cfg_regs[REG_WRIST2_OFFSET]    <= cfg.data;
        REG_TOOL_OFFSET:      cfg_regs[REG_TOOL_OFFSET]      <= cfg.data;
        default: ;
      endcase
    end
  end

  // front end: angle intake and sin/cos
  dhfk_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .joints    (joints),
    .lengths   (cfg_regs),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_wdata)
  );

  // decoupling queue
  dhfk_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back end: transform chain and pose register
  dhfk_back u_back (
    .clk     (clk),
    .rst     (rst),
    .lengths (cfg_regs),
    .head    (q_rdata),
    .q_stat  (q_stat),
    .pop     (q_pop),
    .pose    (pose)
  );

  // no push into a full queue, no pop from an empty one
  `DHFK_ASSERT_IMP(a_push_not_full, q_push, !q_stat.full)
  `DHFK_ASSERT_IMP(a_pop_not_empty, q_pop, !q_stat.empty)
  // every pop loads a pose into the output register
  `DHFK_ASSERT_NEXT(a_pop_loads_pose, q_pop, pose.valid)
endmodule
`default_nettype wire
